// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    // sizing
    localparam int DEPTH     = 16;
    localparam int PRIO_BITS = 8;
    localparam int DATA_BITS = 32;
    localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int OCC_BITS  = 5;

    // stream widths, packed fields padded to whole bytes
    localparam int S_TDATA_BITS = ((PRIO_BITS + DATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((PRIO_BITS + DATA_BITS + OCC_BITS + 7) / 8) * 8;

    // operation codes
    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // one queue slot
    typedef struct packed {
        logic [PRIO_BITS-1:0] prio;
        logic [DATA_BITS-1:0] data;
    } entry_t;

    // sequencer request to the entry store
    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        entry_t              wentry;
        logic [IDX_BITS-1:0] raddr;
    } store_req_t;

endpackage

// ----- hdl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue kept in sorted order, highest priority at the head
// ----------------------------------------------------------------------------
// Usage: one operation per input transfer on the s_ group, one result per
// operation on the m_ group. s_tuser selects insert or remove; s_tdata
// carries the priority and payload of an insert. Equal priorities leave in
// arrival order. m_tuser gives the status (done, full, empty); m_tdata the
// removed priority and payload (zero otherwise) and the occupancy after.
// A rejected insert or empty remove goes straight to the done state. An
// insert reads and compares one slot at a time from the tail, moving each
// lower entry one slot towards the tail; a remove takes the head, then
// moves each later entry one slot towards the head. The compare-and-move
// sequencer walks the single read port of the store one slot at a time.
// s_tready is high only while the sequencer is idle; one operation at a time.
// Reset empties the queue at once; store contents are not cleared.
// A stalled receiver holds the result in the output register; the next
// operation is still taken and worked, and waits only to publish its result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,   // priority_req, payload
    input  logic                    s_tuser,   // func
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,   // out_priority, out_payload, occupancy
    output logic [1:0]              m_tuser    // status
);

    func_t                in_func;
    logic [PRIO_BITS-1:0] in_prio;
    logic [DATA_BITS-1:0] in_data;
    status_t              res_status;
    logic [PRIO_BITS-1:0] res_prio;
    logic [DATA_BITS-1:0] res_data;
    logic [OCC_BITS-1:0]  res_occ;
    store_req_t           store_req;
    entry_t               rd_entry;
    logic                 res_zero;
    logic                 status_known;

    // unpack input transfer
    assign in_func = func_t'(s_tuser);
    assign in_prio = s_tdata[PRIO_BITS-1:0];
    assign in_data = s_tdata[PRIO_BITS+DATA_BITS-1:PRIO_BITS];

    spq_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_func    (in_func),
        .in_prio    (in_prio),
        .in_data    (in_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .res_status (res_status),
        .res_prio   (res_prio),
        .res_data   (res_data),
        .res_occ    (res_occ),
        .store_req  (store_req),
        .rd_entry   (rd_entry)
    );

    spq_store u_store
    (
        .clk      (clk),
        .req      (store_req),
        .rd_entry (rd_entry)
    );

    // pack result transfer
    assign m_tdata = M_TDATA_BITS'({res_occ, res_data, res_prio});
    assign m_tuser = res_status;

    // terms for the checks
    assign res_zero     = (res_status == ST_OK) || ((res_prio == '0) && (res_data == '0));
    assign status_known = (res_status == ST_OK) || (res_status == ST_FULL) ||
                          (res_status == ST_EMPTY);

    // checks
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `ASSERT_ALWAYS(a_zero_unless_removed, !m_tvalid || res_zero, "nonzero fields on failed op")
    `ASSERT_ALWAYS(a_occ_bounded, !m_tvalid || 32'(res_occ) <= 32'(DEPTH), "occupancy overflow")
    `ASSERT_ALWAYS(a_status_code, !m_tvalid || status_known, "bad status code")

endmodule

// ----- hdl/spq_store.sv -----
// ----------------------------------------------------------------------------
// spq_store
// entry memory, one write and one registered read port
// ----------------------------------------------------------------------------
module spq_store
    import spq_pkg::*;
(
    input  logic       clk,
    input  store_req_t req,
    output entry_t     rd_entry
);

    entry_t mem [DEPTH];
    entry_t rd_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wentry;
        end
        rd_reg <= mem[req.raddr];
    end

    assign rd_entry = rd_reg;

endmodule

// ----- hdl/spq_seq.sv -----
// ----------------------------------------------------------------------------
// spq_seq
// sequencer walking the entry store through one compare unit
// ----------------------------------------------------------------------------
module spq_seq
    import spq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  func_t                in_func,
    input  logic [PRIO_BITS-1:0] in_prio,
    input  logic [DATA_BITS-1:0] in_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output status_t              res_status,
    output logic [PRIO_BITS-1:0] res_prio,
    output logic [DATA_BITS-1:0] res_data,
    output logic [OCC_BITS-1:0]  res_occ,
    output store_req_t           store_req,
    input  entry_t               rd_entry
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_INS_RD   = 7'b0000010,
        S_INS_CMP  = 7'b0000100,
        S_REM_HEAD = 7'b0001000,
        S_REM_RD   = 7'b0010000,
        S_REM_MV   = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t               state_reg,  state_next;
    logic [CNT_BITS-1:0]  idx_reg,    idx_next;
    logic [CNT_BITS-1:0]  count_reg,  count_next;
    logic                 ovalid_reg, ovalid_next;
    logic [PRIO_BITS-1:0] prio_reg,   prio_next;
    logic [DATA_BITS-1:0] data_reg,   data_next;
    status_t              pstat_reg,  pstat_next;
    logic [PRIO_BITS-1:0] pprio_reg,  pprio_next;
    logic [DATA_BITS-1:0] pdata_reg,  pdata_next;
    status_t              ostat_reg,  ostat_next;
    logic [PRIO_BITS-1:0] oprio_reg,  oprio_next;
    logic [DATA_BITS-1:0] odata_reg,  odata_next;
    logic [OCC_BITS-1:0]  oocc_reg,   oocc_next;

    logic                 accept;
    logic                 lower;
    logic [CNT_BITS-1:0]  idx_dec;
    logic [CNT_BITS-1:0]  idx_inc;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign idx_dec  = idx_reg - CNT_BITS'(1);
    assign idx_inc  = idx_reg + CNT_BITS'(1);

    // shared compare unit: held entry ranks below the new one
    assign lower = (rd_entry.prio < prio_reg);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        ovalid_next = ovalid_reg;
        prio_next   = prio_reg;
        data_next   = data_reg;
        pstat_next  = pstat_reg;
        pprio_next  = pprio_reg;
        pdata_next  = pdata_reg;
        ostat_next  = ostat_reg;
        oprio_next  = oprio_reg;
        odata_next  = odata_reg;
        oocc_next   = oocc_reg;

        store_req.we            = 1'b0;
        store_req.waddr         = idx_reg[IDX_BITS-1:0];
        store_req.wentry.prio   = prio_reg;
        store_req.wentry.data   = data_reg;
        store_req.raddr         = '0;

        // output register drains on a transfer
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    prio_next  = in_prio;
                    data_next  = in_data;
                    pstat_next = ST_OK;
                    pprio_next = '0;
                    pdata_next = '0;
                    if (in_func == FUNC_INSERT)
                    begin
                        if (count_reg == CNT_BITS'(DEPTH))
                        begin
                            pstat_next = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            pstat_next = ST_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            // fetch the head slot
                            store_req.raddr = '0;
                            state_next      = S_REM_HEAD;
                        end
                    end
                end
            end

            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    // new entry becomes the head
                    store_req.we = 1'b1;
                    count_next   = count_reg + CNT_BITS'(1);
                    state_next   = S_DONE;
                end
                else
                begin
                    store_req.raddr = idx_dec[IDX_BITS-1:0];
                    state_next      = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                store_req.we = 1'b1;
                if (lower)
                begin
                    // move the lower entry one slot towards the tail
                    store_req.wentry = rd_entry;
                    idx_next         = idx_dec;
                    state_next       = S_INS_RD;
                end
                else
                begin
                    // equal or higher entry found, place behind it
                    count_next = count_reg + CNT_BITS'(1);
                    state_next = S_DONE;
                end
            end

            S_REM_HEAD:
            begin
                pprio_next = rd_entry.prio;
                pdata_next = rd_entry.data;
                idx_next   = CNT_BITS'(1);
                state_next = S_REM_RD;
            end

            S_REM_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = count_reg - CNT_BITS'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    store_req.raddr = idx_reg[IDX_BITS-1:0];
                    state_next      = S_REM_MV;
                end
            end

            S_REM_MV:
            begin
                // move entry one slot towards the head
                store_req.we     = 1'b1;
                store_req.waddr  = idx_dec[IDX_BITS-1:0];
                store_req.wentry = rd_entry;
                idx_next         = idx_inc;
                state_next       = S_REM_RD;
            end

            S_DONE:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = pstat_reg;
                    oprio_next  = pprio_reg;
                    odata_next  = pdata_reg;
                    oocc_next   = OCC_BITS'(count_reg);
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        prio_reg  <= prio_next;
        data_reg  <= data_next;
        pstat_reg <= pstat_next;
        pprio_reg <= pprio_next;
        pdata_reg <= pdata_next;
        ostat_reg <= ostat_next;
        oprio_reg <= oprio_next;
        odata_reg <= odata_next;
        oocc_reg  <= oocc_next;
    end

    assign m_tvalid   = ovalid_reg;
    assign res_status = ostat_reg;
    assign res_prio   = oprio_reg;
    assign res_data   = odata_reg;
    assign res_occ    = oocc_reg;

endmodule

// ----- test/sorted_priority_queue_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// self-checking bench for the sorted priority queue
// ----------------------------------------------------------------------------
// Drives insert and remove operations on the s_ stream. A shadow copy of the
// sorted queue predicts each m_ result: status, removed entry and occupancy.
// Covers empty removes, full inserts, tie ordering and field extremes. After
// that, random traffic with fill and drain bias runs under three idling
// patterns on both stream sides.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 2 * DEPTH + 8;

    typedef struct {
        status_t              status;
        logic [PRIO_BITS-1:0] prio;
        logic [DATA_BITS-1:0] data;
        logic [OCC_BITS-1:0]  occ;
    } queue_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;   // priority_req, payload
    logic                    s_tuser = 1'b0; // func
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;        // out_priority, out_payload, occupancy
    logic [1:0]              m_tuser;        // status

    // shadow copy of the sorted queue
    logic [PRIO_BITS-1:0] shadow_prio [DEPTH];
    logic [DATA_BITS-1:0] shadow_data [DEPTH];
    int                   shadow_count = 0;

    queue_result_t pending_results [$];
    int            failures = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            quiet_cycles = 0;

    sorted_priority_queue u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // sorted insert after equal or higher entries, remove from the head
    function automatic queue_result_t apply_queue_op(func_t op,
                                                     logic [PRIO_BITS-1:0] prio,
                                                     logic [DATA_BITS-1:0] data);
        queue_result_t res;
        int            slot;
        res.status = ST_OK;
        res.prio   = '0;
        res.data   = '0;
        if (op == FUNC_INSERT)
        begin
            if (shadow_count >= DEPTH)
                res.status = ST_FULL;
            else
            begin
                slot = 0;
                while (slot < shadow_count && shadow_prio[slot] >= prio)
                    slot++;
                for (int i = shadow_count; i > slot; i--)
                begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_data[i] = shadow_data[i-1];
                end
                shadow_prio[slot] = prio;
                shadow_data[slot] = data;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                res.status = ST_EMPTY;
            else
            begin
                res.prio = shadow_prio[0];
                res.data = shadow_data[0];
                for (int i = 1; i < shadow_count; i++)
                begin
                    shadow_prio[i-1] = shadow_prio[i];
                    shadow_data[i-1] = shadow_data[i];
                end
                shadow_count--;
            end
        end
        res.occ = OCC_BITS'(shadow_count);
        return res;
    endfunction

    task automatic note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // one operation transfer on the s_ side, with random gaps before it
    task automatic send_op(func_t op, logic [PRIO_BITS-1:0] prio,
                           logic [DATA_BITS-1:0] data);
        logic [S_TDATA_BITS-1:0] word;
        word = '0;
        word[PRIO_BITS-1:0] = prio;
        word[PRIO_BITS+DATA_BITS-1:PRIO_BITS] = data;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_queue_op(op, prio, data));
    endtask

    // hold the sender until every expected result has come back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // priorities biased towards ties and extremes
    function automatic logic [PRIO_BITS-1:0] pick_prio();
        case ($urandom_range(0, 3))
            0: return PRIO_BITS'($urandom);
            1: return PRIO_BITS'($urandom_range(0, 3));
            2: return $urandom_range(0, 1) ? '1 : '0;
            default: return PRIO_BITS'($urandom_range(120, 135));
        endcase
    endfunction

    task automatic test_directed();
        send_op(FUNC_REMOVE, '0, '0);
        send_op(FUNC_INSERT, '0, '0);
        send_op(FUNC_INSERT, '1, '1);
        send_op(FUNC_INSERT, '1, 32'h1234_5678);
        send_op(FUNC_INSERT, 8'h55, 32'h5555_5555);
        send_op(FUNC_INSERT, 8'hAA, 32'hAAAA_AAAA);
        send_op(FUNC_INSERT, '0, 32'hA5A5_A5A5);
        send_op(FUNC_INSERT, 8'h80, 32'h0000_0001);
        send_op(FUNC_INSERT, '1, 32'h8000_0000);
        // drain, ties at the head must leave in arrival order
        while (shadow_count > 0)
            send_op(FUNC_REMOVE, '1, '1);
        send_op(FUNC_REMOVE, '1, '1);
    endtask

    // fill past full then drain past empty, random content
    task automatic test_full_queue();
        while (shadow_count < DEPTH)
            send_op(FUNC_INSERT, pick_prio(), $urandom);
        send_op(FUNC_INSERT, pick_prio(), $urandom);
        send_op(FUNC_INSERT, pick_prio(), $urandom);
        while (shadow_count > 0)
            send_op(FUNC_REMOVE, PRIO_BITS'($urandom), $urandom);
        send_op(FUNC_REMOVE, PRIO_BITS'($urandom), $urandom);
    endtask

    // random mix in stretches, each biased at random towards filling or draining
    task automatic test_random_mix(int count);
        int    insert_pct;
        func_t op;
        insert_pct = 50;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                insert_pct = $urandom_range(0, 1) ? 75 : 30;
            op = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
            send_op(op, pick_prio(), $urandom);
        end
    endtask

    // receiver readiness
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // result checking against the oldest expectation
    always @(posedge clk)
    begin : check_results
        queue_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                note_failure("result transfer with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                    note_failure($sformatf("status expected %0d got %0d",
                                           want.status, m_tuser));
                if (m_tdata[PRIO_BITS-1:0] !== want.prio)
                    note_failure($sformatf("out_priority expected %0h got %0h",
                                           want.prio, m_tdata[PRIO_BITS-1:0]));
                if (m_tdata[PRIO_BITS+DATA_BITS-1:PRIO_BITS] !== want.data)
                    note_failure($sformatf("out_payload expected %0h got %0h", want.data,
                                           m_tdata[PRIO_BITS+DATA_BITS-1:PRIO_BITS]));
                if (m_tdata[PRIO_BITS+DATA_BITS+OCC_BITS-1:PRIO_BITS+DATA_BITS]
                    !== want.occ)
                    note_failure($sformatf("occupancy expected %0d got %0d", want.occ,
                        m_tdata[PRIO_BITS+DATA_BITS+OCC_BITS-1:PRIO_BITS+DATA_BITS]));
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 9;
        recv_idle_pct = 81;
        test_directed();
        test_full_queue();
        test_random_mix(340);
        wait_all_results();

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 81;
        recv_idle_pct = 9;
        test_full_queue();
        test_random_mix(340);
        wait_all_results();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(200);
        test_full_queue();
        test_random_mix(140);

        wait_all_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure("expected results left over");
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_store.sv
hdl/spq_seq.sv
hdl/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
